### sv/heightmap_bilinear_sampler_core_macros.svh
// assertion macros for the heightmap sampler
// expects clk and rst_n in the scope where a macro is used
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define HBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles, held off during reset
`define HBS_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

### sv/hbs_pkg.sv
// shared constants, codes and types of the heightmap sampler
// no dependencies
package hbs_pkg;

  // map geometry and store size
  localparam int SQUARE_SIZE  = 8;    // world units per square, power of two
  localparam int SQUARE_SHIFT = $clog2(SQUARE_SIZE);
  localparam int STORE_DEPTH  = 4096;
  localparam int MAX_SQUARES  = 63;

  // field widths
  localparam int SQ_W    = 6;
  localparam int POS_W   = 24;
  localparam int RAW_W   = 16;
  localparam int FRAC_W  = 8;
  localparam int H_W     = 32;
  localparam int SCALE_W = 24;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // raw times scale is in 2^-24, output in 2^-16
  localparam int SCALE_SHIFT = 8;

  // store addressing, two banks split on the address parity
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int BANK_DEPTH = STORE_DEPTH / 2;
  localparam int BANK_AW    = ADDR_W - 1;
  localparam int LIN_W      = (2 * SQ_W + 1 > ADDR_W) ? 2 * SQ_W + 1 : ADDR_W;
  localparam int GRID_W     = SQ_W + FRAC_W;

  localparam logic [H_W-1:0] H_MAX = {1'b0, {(H_W-1){1'b1}}};

  // operations
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_WORLD  = 2'd2;

  // what the result of an item is made from
  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_BASE   = 2'd1;
  localparam logic [1:0] KIND_INTERP = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SQUARES_X   = 2'd0;
  localparam logic [1:0] REG_SQUARES_Z   = 2'd1;
  localparam logic [1:0] REG_BASE_HEIGHT = 2'd2;
  localparam logic [1:0] REG_SCALE       = 2'd3;

  // store port requests of one item
  typedef struct packed {
    logic               we;
    logic               wbank;
    logic [BANK_AW-1:0] waddr;
    logic [RAW_W-1:0]   wdata;
    logic [BANK_AW-1:0] ra_even0;
    logic [BANK_AW-1:0] ra_odd0;
    logic [BANK_AW-1:0] ra_even1;
    logic [BANK_AW-1:0] ra_odd1;
  } hbs_mem_req_t;

  // what travels alongside the store read
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    logic              p00;
    logic              p10;
    logic              p01;
    logic              p11;
  } hbs_tag_t;

endpackage

### sv/hbs_ram.sv
// generic synchronous ram, one write port and two registered read ports
// no dependencies
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads, a read in the write cycle sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/hbs_addr.sv
// grid mapping and corner address generation of the heightmap sampler
// depends on hbs_pkg
module hbs_addr
  import hbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  logic [1:0]              op,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [RAW_W-1:0]        sample,
  input  logic [SQ_W-1:0]         sx,
  input  logic [SQ_W-1:0]         sz,
  output hbs_mem_req_t            mem_req,
  output hbs_tag_t                tag
);

  localparam int G_W = POS_W - 1 - SQUARE_SHIFT;

  // first stage registers
  logic              valid_r, valid_nxt;
  logic              wr_r, wr_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [SQ_W-1:0]   x0_r, x0_nxt;
  logic [SQ_W-1:0]   z0_r, z0_nxt;
  logic              dx_r, dx_nxt;
  logic              dz_r, dz_nxt;
  logic [FRAC_W-1:0] fx_r, fx_nxt;
  logic [FRAC_W-1:0] fz_r, fz_nxt;
  logic [RAW_W-1:0]  sample_r;

  logic signed [POS_W-1:0] sx_s, sz_s;
  logic                    big_x, big_z;
  logic [SQ_W-1:0]         cx, cz;
  logic [G_W-1:0]          gpx, gpz;
  logic [GRID_W-1:0]       lim_x, lim_z, gx, gz;
  logic                    empty, in_grid;

  // coordinate clamping and world to grid mapping
  always_comb begin
    sx_s  = $signed({{(POS_W-SQ_W){1'b0}}, sx});
    sz_s  = $signed({{(POS_W-SQ_W){1'b0}}, sz});
    big_x = pos_x > sx_s;
    big_z = pos_z > sz_s;
    cx    = pos_x[POS_W-1] ? '0 : (big_x ? sx : pos_x[SQ_W-1:0]);
    cz    = pos_z[POS_W-1] ? '0 : (big_z ? sz : pos_z[SQ_W-1:0]);
    in_grid = !pos_x[POS_W-1] && !pos_z[POS_W-1] && !big_x && !big_z;
    empty   = (sx == '0) || (sz == '0);

    gpx   = pos_x[POS_W-2:SQUARE_SHIFT];
    gpz   = pos_z[POS_W-2:SQUARE_SHIFT];
    lim_x = {sx, {FRAC_W{1'b0}}};
    lim_z = {sz, {FRAC_W{1'b0}}};
    gx    = pos_x[POS_W-1] ? '0 : ((gpx > G_W'(lim_x)) ? lim_x : gpx[GRID_W-1:0]);
    gz    = pos_z[POS_W-1] ? '0 : ((gpz > G_W'(lim_z)) ? lim_z : gpz[GRID_W-1:0]);
  end

  // per-operation choice of corner, step and fraction
  always_comb begin
    valid_nxt = acc;
    wr_nxt    = 1'b0;
    kind_nxt  = KIND_ZERO;
    x0_nxt    = cx;
    z0_nxt    = cz;
    dx_nxt    = 1'b0;
    dz_nxt    = 1'b0;
    fx_nxt    = '0;
    fz_nxt    = '0;
    case (op)
      OP_WRITE: begin
        wr_nxt = in_grid;
      end
      OP_VERTEX: begin
        kind_nxt = empty ? KIND_BASE : KIND_INTERP;
      end
      OP_WORLD: begin
        kind_nxt = empty ? KIND_BASE : KIND_INTERP;
        x0_nxt   = gx[GRID_W-1:FRAC_W];
        z0_nxt   = gz[GRID_W-1:FRAC_W];
        fx_nxt   = gx[FRAC_W-1:0];
        fz_nxt   = gz[FRAC_W-1:0];
        // edge corner: the step past the edge is dropped
        dx_nxt   = gx[GRID_W-1:FRAC_W] < sx;
        dz_nxt   = gz[GRID_W-1:FRAC_W] < sz;
      end
      default: begin
        kind_nxt = KIND_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_r     <= wr_nxt;
    kind_r   <= kind_nxt;
    x0_r     <= x0_nxt;
    z0_r     <= z0_nxt;
    dx_r     <= dx_nxt;
    dz_r     <= dz_nxt;
    fx_r     <= fx_nxt;
    fz_r     <= fz_nxt;
    sample_r <= sample;
  end

  logic [LIN_W-1:0] row_w, z0_l, x0_l;
  logic [LIN_W-1:0] a00, a10, a01, a11;
  logic [LIN_W-1:0] e0, o0, e1, o1;
  logic             ok;

  // linear corner addresses, z * (squares + 1) + x
  always_comb begin
    row_w = LIN_W'(sx) + LIN_W'(1);
    z0_l  = LIN_W'(z0_r);
    x0_l  = LIN_W'(x0_r);
    a00   = LIN_W'(z0_l * row_w) + x0_l;
    a01   = a00 + (dz_r ? row_w : '0);
    a10   = a00 + LIN_W'(dx_r);
    a11   = a01 + LIN_W'(dx_r);
    ok    = 32'(a11) < 32'(STORE_DEPTH);
    // even and odd member of each row pair
    e0    = a00[0] ? a10 : a00;
    o0    = a00[0] ? a00 : a10;
    e1    = a01[0] ? a11 : a01;
    o1    = a01[0] ? a01 : a11;
  end

  // store requests and tag for the read stage
  always_comb begin
    mem_req.we       = valid_r && wr_r && ok;
    mem_req.wbank    = a00[0];
    mem_req.waddr    = a00[ADDR_W-1:1];
    mem_req.wdata    = sample_r;
    mem_req.ra_even0 = e0[ADDR_W-1:1];
    mem_req.ra_odd0  = o0[ADDR_W-1:1];
    mem_req.ra_even1 = e1[ADDR_W-1:1];
    mem_req.ra_odd1  = o1[ADDR_W-1:1];

    tag.valid = valid_r;
    // a corner past the store reads as base
    tag.kind  = (kind_r == KIND_INTERP && !ok) ? KIND_BASE : kind_r;
    tag.fx    = fx_r;
    tag.fz    = fz_r;
    tag.p00   = a00[0];
    tag.p10   = a10[0];
    tag.p01   = a01[0];
    tag.p11   = a11[0];
  end

endmodule

### sv/hbs_interp.sv
// bilinear blend, scale decode and saturation of the heightmap sampler
// depends on hbs_pkg
module hbs_interp
  import hbs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  hbs_tag_t                  tag,
  input  logic [RAW_W-1:0]          q_even0,
  input  logic [RAW_W-1:0]          q_odd0,
  input  logic [RAW_W-1:0]          q_even1,
  input  logic [RAW_W-1:0]          q_odd1,
  input  logic signed [H_W-1:0]     base,
  input  logic [SCALE_W-1:0]        scale,
  output logic                      out_valid,
  output logic signed [H_W-1:0]     out_height
);

  localparam int WT_W  = FRAC_W + 1;
  localparam int RA_W  = RAW_W + FRAC_W;
  localparam int B_W   = RAW_W + 2 * FRAC_W;
  localparam int P_W   = B_W + SCALE_W;
  localparam int SH    = SCALE_SHIFT + 2 * FRAC_W;
  localparam int Q_W   = P_W + 1 - SH;
  localparam int SUM_W = Q_W + 1;
  localparam logic [WT_W-1:0] WT_ONE = WT_W'(1) << FRAC_W;

  // tag aligned with the store read data
  hbs_tag_t t2_r;
  logic     t2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_valid_r <= 1'b0;
    end else begin
      t2_valid_r <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    t2_r <= tag;
  end

  logic [RAW_W-1:0] h00, h10, h01, h11;
  logic [WT_W-1:0]  wx1, wx0;
  logic [RA_W:0]    ra_sum, rb_sum;

  // corner pick from the banks and blend along x
  always_comb begin
    h00    = t2_r.p00 ? q_odd0 : q_even0;
    h10    = t2_r.p10 ? q_odd0 : q_even0;
    h01    = t2_r.p01 ? q_odd1 : q_even1;
    h11    = t2_r.p11 ? q_odd1 : q_even1;
    wx1    = WT_W'(t2_r.fx);
    wx0    = WT_ONE - wx1;
    ra_sum = (RA_W+1)'(h00) * (RA_W+1)'(wx0) + (RA_W+1)'(h10) * (RA_W+1)'(wx1);
    rb_sum = (RA_W+1)'(h01) * (RA_W+1)'(wx0) + (RA_W+1)'(h11) * (RA_W+1)'(wx1);
  end

  logic              v3_r;
  logic [1:0]        kind3_r;
  logic [FRAC_W-1:0] fz3_r;
  logic [RA_W-1:0]   ra_r, rb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= t2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    kind3_r <= t2_r.kind;
    fz3_r   <= t2_r.fz;
    ra_r    <= ra_sum[RA_W-1:0];
    rb_r    <= rb_sum[RA_W-1:0];
  end

  logic [WT_W-1:0] wz1, wz0;
  logic [B_W:0]    b_sum;

  // blend along z
  always_comb begin
    wz1   = WT_W'(fz3_r);
    wz0   = WT_ONE - wz1;
    b_sum = (B_W+1)'(ra_r) * (B_W+1)'(wz0) + (B_W+1)'(rb_r) * (B_W+1)'(wz1);
  end

  logic           v4_r;
  logic [1:0]     kind4_r;
  logic [B_W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    kind4_r <= kind3_r;
    b_r     <= b_sum[B_W-1:0];
  end

  // scale multiply
  logic           v5_r;
  logic [1:0]     kind5_r;
  logic [P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    kind5_r <= kind4_r;
    p_r     <= P_W'(b_r) * P_W'(scale);
  end

  logic [P_W:0]       p_rnd;
  logic [Q_W-1:0]     q;
  logic [SUM_W-1:0]   h_sum;
  logic               sat;
  logic [H_W-1:0]     h_dec;
  logic [H_W-1:0]     height_nxt;

  // round half up, add base, saturate upwards (the sum never falls below base)
  always_comb begin
    p_rnd = (P_W+1)'(p_r) + ((P_W+1)'(1) << (SH - 1));
    q     = p_rnd[P_W:SH];
    h_sum = {{(SUM_W-H_W){base[H_W-1]}}, base} + SUM_W'(q);
    sat   = h_sum[SUM_W-1:H_W-1] != {(SUM_W-H_W+1){h_sum[H_W-1]}};
    h_dec = sat ? H_MAX : h_sum[H_W-1:0];
    case (kind5_r)
      KIND_ZERO:   height_nxt = '0;
      KIND_BASE:   height_nxt = base;
      KIND_INTERP: height_nxt = h_dec;
      default:     height_nxt = '0;
    endcase
  end

  logic           out_valid_r;
  logic [H_W-1:0] out_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    out_height_r <= height_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_height = $signed(out_height_r);

endmodule

### sv/heightmap_bilinear_sampler_core.sv
// top level of the heightmap sampler: register port, banked store, pipeline
// depends on hbs_pkg, hbs_addr, hbs_ram, hbs_interp and the assertion macros
//
//   channel   ports                                  handshake
//   item in   in_operation in_pos_x in_pos_z         start high, busy low
//             in_sample
//   result    out_height                             out_valid, one cycle
//   config    psel penable pwrite paddr pwdata       access phase, pready high
//             prdata
//
// one item is taken every cycle; busy stays low
// a result passes these steps in order after its item: address multiply, store read,
// blend along x, blend along z, scale multiply, rounding and saturation
// the two parity banks give the four corners of a square in a single read
// synchronous reset clears the pipeline valid flags and the registers; the store keeps
// its contents and is not swept
// results cannot be held off, so nothing in the pipeline ever stalls
`include "heightmap_bilinear_sampler_core_macros.svh"

module heightmap_bilinear_sampler_core
  import hbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_operation,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [RAW_W-1:0]        in_sample,
  output logic                    out_valid,
  output logic signed [H_W-1:0]   out_height,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  // configuration registers
  logic [SQ_W-1:0]    sq_x_r, sq_x_nxt;
  logic [SQ_W-1:0]    sq_z_r, sq_z_nxt;
  logic [H_W-1:0]     base_r, base_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    sq_x_nxt  = sq_x_r;
    sq_z_nxt  = sq_z_r;
    base_nxt  = base_r;
    scale_nxt = scale_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_SQUARES_X:   sq_x_nxt  = pwdata[SQ_W-1:0];
        REG_SQUARES_Z:   sq_z_nxt  = pwdata[SQ_W-1:0];
        REG_BASE_HEIGHT: base_nxt  = pwdata[H_W-1:0];
        REG_SCALE:       scale_nxt = pwdata[SCALE_W-1:0];
        default:         sq_x_nxt  = sq_x_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_x_r  <= '0;
      sq_z_r  <= '0;
      base_r  <= '0;
      scale_r <= '0;
    end else begin
      sq_x_r  <= sq_x_nxt;
      sq_z_r  <= sq_z_nxt;
      base_r  <= base_nxt;
      scale_r <= scale_nxt;
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_SQUARES_X:   prdata = DATA_W'(sq_x_r);
      REG_SQUARES_Z:   prdata = DATA_W'(sq_z_r);
      REG_BASE_HEIGHT: prdata = DATA_W'(base_r);
      REG_SCALE:       prdata = DATA_W'(scale_r);
      default:         prdata = '0;
    endcase
  end

  // square counts in use
  logic [SQ_W-1:0] sx_used, sz_used;

  assign sx_used = (32'(sq_x_r) > MAX_SQUARES) ? SQ_W'(MAX_SQUARES) : sq_x_r;
  assign sz_used = (32'(sq_z_r) > MAX_SQUARES) ? SQ_W'(MAX_SQUARES) : sq_z_r;

  // address generation
  logic         acc;
  hbs_mem_req_t mem_req;
  hbs_tag_t     tag;

  assign acc = start && !busy;

  hbs_addr u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .op      (in_operation),
    .pos_x   (in_pos_x),
    .pos_z   (in_pos_z),
    .sample  (in_sample),
    .sx      (sx_used),
    .sz      (sz_used),
    .mem_req (mem_req),
    .tag     (tag)
  );

  // store, even and odd linear addresses in separate banks
  logic [RAW_W-1:0] q_even0, q_even1, q_odd0, q_odd1;

  hbs_ram #(
    .WIDTH (RAW_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk     (clk),
    .we      (mem_req.we && !mem_req.wbank),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.ra_even0),
    .raddr_b (mem_req.ra_even1),
    .rdata_a (q_even0),
    .rdata_b (q_even1)
  );

  hbs_ram #(
    .WIDTH (RAW_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk     (clk),
    .we      (mem_req.we && mem_req.wbank),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.ra_odd0),
    .raddr_b (mem_req.ra_odd1),
    .rdata_a (q_odd0),
    .rdata_b (q_odd1)
  );

  // blend and decode
  hbs_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (tag),
    .q_even0    (q_even0),
    .q_odd0     (q_odd0),
    .q_even1    (q_even1),
    .q_odd1     (q_odd1),
    .base       ($signed(base_r)),
    .scale      (scale_r),
    .out_valid  (out_valid),
    .out_height (out_height)
  );

  // every item gives exactly one result at a fixed distance
  `HBS_ASSERT_DLY(a_item_result, start && !busy, 6, out_valid, "item gave no result")
  `HBS_ASSERT_IMP(a_result_item, out_valid, $past(start && !busy, 6), "result without an item")
  `HBS_ASSERT_IMP(a_write_zero, out_valid && $past(start && !busy && in_operation == OP_WRITE, 6), out_height == '0, "write item gave a nonzero height")

endmodule
